[hdl/pcs_pkg.sv]
// Package with shared constants for the polygon centroid and support unit.
package pcs_pkg;
    localparam int MAX_VERTICES_DEF = 64;
    localparam int COORD_BITS_DEF   = 16;
    localparam int IDX_BITS         = 6;
    localparam int STATUS_BITS      = 2;

    localparam logic [STATUS_BITS-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_DEGENERATE = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY      = 2'd2;

    localparam logic KIND_CENTROID = 1'b0;
    localparam logic KIND_SUPPORT  = 1'b1;

    localparam logic FUNC_APPEND  = 1'b0;
    localparam logic FUNC_SUPPORT = 1'b1;
endpackage

[hdl/polygon_centroid_and_support_unit.sv]
// Top level of the polygon centroid and support unit.
//
// Commands enter on start while busy is low; each field is a port.
// An append word (func = 0) stores a vertex and busy stays low.
// The first append after a centroid result, or after reset, restarts the store.
// An append with last_vertex set, or a support query (func = 1), raises busy
// while the sequencer walks the vertex memory one entry per cycle.
// A support query on an empty store answers in the next cycle without busy.
// Otherwise the support result follows once the walk and the compare stage drain.
// A centroid walk passes each edge through a multiply chain of edge, product
// and cross-product registers; a single vertex or a zero area answers after it.
// Otherwise two serial divisions of width DW follow,
// where DW = 3*COORD_BITS + 8 + clog2(MAX_VERTICES+1).
// Busy drops in the cycle after the result, and the next word may enter then.
// The result word is shown for exactly one cycle with valid high; the
// receiver cannot stall it. Reset empties the store and clears busy.
// The vertex memory needs no clearing pass: only written entries are read.
module polygon_centroid_and_support_unit
    import pcs_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int COORD_BITS   = COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         func,
    input  logic signed [COORD_BITS-1:0] pos_x,
    input  logic signed [COORD_BITS-1:0] pos_y,
    input  logic                         last_vertex,
    input  logic signed [COORD_BITS-1:0] dir_x,
    input  logic signed [COORD_BITS-1:0] dir_y,
    output logic                         valid,
    output logic                         kind,
    output logic signed [COORD_BITS-1:0] res_x,
    output logic signed [COORD_BITS-1:0] res_y,
    output logic [IDX_BITS-1:0]          vertex_index,
    output logic [STATUS_BITS-1:0]       status
);
    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int C  = COORD_BITS;
    localparam int PW = 2 * C + 2;
    localparam int SW = 3 * C + 4 + CW;
    localparam int DW = SW + 4;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_SUP   = 8'b00000010,
        S_CEN   = 8'b00000100,
        S_DRAIN = 8'b00001000,
        S_DIVX  = 8'b00010000,
        S_DIVY  = 8'b00100000,
        S_OUT   = 8'b01000000,
        S_WAIT  = 8'b10000000
    } state_t;

    state_t state_reg, state_next;

    logic [CW-1:0] count_reg, count_next;
    logic          restart_reg, restart_next;
    logic [CW-1:0] rd_ptr_reg, rd_ptr_next;
    logic          fetch_v_reg;
    logic [AW-1:0] fetch_i_reg;

    logic signed [C-1:0] dx_reg, dy_reg;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [2*C-1:0] wdata, rdata;
    logic signed [C-1:0] rx, ry;

    assign rx = rdata[2*C-1:C];
    assign ry = rdata[C-1:0];

    pcs_ram #(.WIDTH(2 * C), .DEPTH(MAX_VERTICES)) u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    logic          acc;
    logic          app_ok;
    logic [CW-1:0] base_cnt;

    assign acc      = start && !busy;
    assign base_cnt = restart_reg ? '0 : count_reg;
    assign app_ok   = acc && func == FUNC_APPEND && base_cnt < CW'(MAX_VERTICES);
    assign we       = app_ok;
    assign waddr    = base_cnt[AW-1:0];
    assign wdata    = {pos_x, pos_y};
    assign raddr    = rd_ptr_reg[AW-1:0];

    // Support pipeline stage: products, then sum and compare.
    logic signed [PW-1:0] px_reg, py_reg;
    logic                 sv_reg;
    logic [AW-1:0]        si_reg;
    logic signed [C-1:0]  sx_reg, sy_reg;
    logic signed [PW-1:0] best_d_reg, best_d_next, dsum;
    logic [AW-1:0]        best_i_reg, best_i_next;
    logic signed [C-1:0]  best_x_reg, best_x_next, best_y_reg, best_y_next;
    logic                 have_reg, have_next;

    assign dsum = px_reg + py_reg;

    // Centroid pipeline.
    logic signed [C-1:0]  first_x_reg, first_y_reg, prev_x_reg, prev_y_reg;
    logic                 have_prev_reg, have_prev_next;
    logic signed [C-1:0]  ax_reg, ay_reg, bx_reg, by_reg;
    logic                 e_v_reg;
    logic signed [PW-1:0] m1_reg, m2_reg;
    logic signed [C:0]    ex_reg, ey_reg;
    logic                 m_v_reg;
    logic signed [PW-1:0] cr_reg;
    logic signed [C:0]    fx_reg, fy_reg;
    logic                 c_v_reg;
    logic signed [SW-1:0] area_reg, sumx_reg, sumy_reg;
    logic signed [PW+C:0] tx, ty;
    logic                 edge_in;
    logic signed [C-1:0]  ein_ax, ein_ay, ein_bx, ein_by;
    logic                 wrap_reg, wrap_next;

    assign tx = (PW+C+1)'(cr_reg) * (PW+C+1)'(fx_reg);
    assign ty = (PW+C+1)'(cr_reg) * (PW+C+1)'(fy_reg);

    // Divider.
    logic                 div_go;
    logic signed [DW-1:0] div_num, div_den, div_q;
    logic                 div_done;
    logic signed [DW-1:0] den_reg;
    logic signed [C-1:0]  qx_reg, qx_next;

    pcs_divider #(.W(DW)) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .go   (div_go),
        .num  (div_num),
        .den  (div_den),
        .done (div_done),
        .quo  (div_q)
    );

    function automatic logic signed [C-1:0] sat(input logic signed [DW-1:0] v);
        logic signed [DW-1:0] mx;
        logic signed [DW-1:0] mn;
        mx = DW'((64'sd1 <<< (C - 1)) - 1);
        mn = -mx - 1;
        if (v > mx)
        begin
            return mx[C-1:0];
        end
        else if (v < mn)
        begin
            return mn[C-1:0];
        end
        return v[C-1:0];
    endfunction

    // Output registers.
    logic                   valid_reg, valid_next;
    logic                   kind_reg, kind_next;
    logic signed [C-1:0]    rx_reg, rx_next, ry_reg, ry_next;
    logic [IDX_BITS-1:0]    idx_reg, idx_next;
    logic [STATUS_BITS-1:0] st_reg, st_next;
    logic [2:0]             drain_reg, drain_next;

    always_comb
    begin
        edge_in = 1'b0;
        ein_ax  = prev_x_reg;
        ein_ay  = prev_y_reg;
        ein_bx  = rx;
        ein_by  = ry;
        if (fetch_v_reg && state_reg == S_CEN && have_prev_reg)
        begin
            edge_in = 1'b1;
        end
        else if (wrap_reg)
        begin
            edge_in = 1'b1;
            ein_bx  = first_x_reg;
            ein_by  = first_y_reg;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        restart_next   = restart_reg;
        rd_ptr_next    = rd_ptr_reg;
        best_d_next    = best_d_reg;
        best_i_next    = best_i_reg;
        best_x_next    = best_x_reg;
        best_y_next    = best_y_reg;
        have_next      = have_reg;
        have_prev_next = have_prev_reg;
        wrap_next      = 1'b0;
        valid_next     = 1'b0;
        kind_next      = kind_reg;
        rx_next        = rx_reg;
        ry_next        = ry_reg;
        idx_next       = idx_reg;
        st_next        = st_reg;
        drain_next     = drain_reg;
        div_go         = 1'b0;
        div_num        = DW'(sumx_reg);
        div_den        = den_reg;
        qx_next        = qx_reg;

        if (sv_reg && (!have_reg || dsum > best_d_reg))
        begin
            best_d_next = dsum;
            best_i_next = si_reg;
            best_x_next = sx_reg;
            best_y_next = sy_reg;
            have_next   = 1'b1;
        end
        if (fetch_v_reg && state_reg == S_CEN)
        begin
            have_prev_next = 1'b1;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    rd_ptr_next = '0;
                    have_next   = 1'b0;
                    if (func == FUNC_SUPPORT)
                    begin
                        kind_next = KIND_SUPPORT;
                        if (count_reg == '0)
                        begin
                            valid_next = 1'b1;
                            rx_next    = '0;
                            ry_next    = '0;
                            idx_next   = '0;
                            st_next    = ST_EMPTY;
                        end
                        else
                        begin
                            state_next = S_SUP;
                        end
                    end
                    else
                    begin
                        if (app_ok)
                        begin
                            count_next = base_cnt + 1'b1;
                        end
                        else
                        begin
                            count_next = base_cnt;
                        end
                        restart_next = 1'b0;
                        if (last_vertex)
                        begin
                            restart_next   = 1'b1;
                            kind_next      = KIND_CENTROID;
                            have_prev_next = 1'b0;
                            state_next     = S_CEN;
                        end
                    end
                end
            end
            S_SUP:
            begin
                if (rd_ptr_reg == count_reg)
                begin
                    state_next = S_DRAIN;
                    drain_next = 3'd3;
                end
                else
                begin
                    rd_ptr_next = rd_ptr_reg + 1'b1;
                end
            end
            S_CEN:
            begin
                if (rd_ptr_reg == count_reg)
                begin
                    if (fetch_v_reg == 1'b0)
                    begin
                        wrap_next  = 1'b1;
                        state_next = S_DRAIN;
                        drain_next = 3'd5;
                    end
                end
                else
                begin
                    rd_ptr_next = rd_ptr_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                if (drain_reg != '0)
                begin
                    drain_next = drain_reg - 1'b1;
                end
                else if (kind_reg == KIND_SUPPORT)
                begin
                    valid_next = 1'b1;
                    rx_next    = best_x_reg;
                    ry_next    = best_y_reg;
                    idx_next   = IDX_BITS'(best_i_reg);
                    st_next    = ST_OK;
                    state_next = S_WAIT;
                end
                else if (count_reg == '0)
                begin
                    valid_next = 1'b1;
                    rx_next    = '0;
                    ry_next    = '0;
                    idx_next   = '0;
                    st_next    = ST_EMPTY;
                    state_next = S_WAIT;
                end
                else if (count_reg == CW'(1) || area_reg == '0)
                begin
                    valid_next = 1'b1;
                    rx_next    = first_x_reg;
                    ry_next    = first_y_reg;
                    idx_next   = '0;
                    st_next    = (count_reg == CW'(1)) ? ST_OK : ST_DEGENERATE;
                    state_next = S_WAIT;
                end
                else
                begin
                    div_go     = 1'b1;
                    div_num    = DW'(sumx_reg);
                    div_den    = DW'(area_reg) * DW'(3);
                    state_next = S_DIVX;
                end
            end
            S_DIVX:
            begin
                if (div_done)
                begin
                    qx_next    = sat(div_q);
                    div_go     = 1'b1;
                    div_num    = DW'(sumy_reg);
                    div_den    = den_reg;
                    state_next = S_DIVY;
                end
            end
            S_DIVY:
            begin
                if (div_done)
                begin
                    valid_next = 1'b1;
                    rx_next    = qx_reg;
                    ry_next    = sat(div_q);
                    idx_next   = '0;
                    st_next    = ST_OK;
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                state_next = S_IDLE;
            end
            S_OUT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            restart_reg   <= 1'b1;
            rd_ptr_reg    <= '0;
            fetch_v_reg   <= 1'b0;
            sv_reg        <= 1'b0;
            e_v_reg       <= 1'b0;
            m_v_reg       <= 1'b0;
            c_v_reg       <= 1'b0;
            have_reg      <= 1'b0;
            have_prev_reg <= 1'b0;
            wrap_reg      <= 1'b0;
            valid_reg     <= 1'b0;
            drain_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            restart_reg   <= restart_next;
            rd_ptr_reg    <= rd_ptr_next;
            fetch_v_reg   <= (state_reg == S_SUP || state_reg == S_CEN)
                             && rd_ptr_reg != count_reg;
            sv_reg        <= fetch_v_reg && state_reg == S_SUP;
            e_v_reg       <= edge_in;
            m_v_reg       <= e_v_reg;
            c_v_reg       <= m_v_reg;
            have_reg      <= have_next;
            have_prev_reg <= have_prev_next;
            wrap_reg      <= wrap_next;
            valid_reg     <= valid_next;
            drain_reg     <= drain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fetch_i_reg <= rd_ptr_reg[AW-1:0];
        if (acc)
        begin
            dx_reg <= dir_x;
            dy_reg <= dir_y;
        end
        px_reg <= PW'(dx_reg) * PW'(rx);
        py_reg <= PW'(dy_reg) * PW'(ry);
        si_reg <= fetch_i_reg;
        sx_reg <= rx;
        sy_reg <= ry;
        best_d_reg <= best_d_next;
        best_i_reg <= best_i_next;
        best_x_reg <= best_x_next;
        best_y_reg <= best_y_next;

        if (fetch_v_reg && state_reg == S_CEN)
        begin
            prev_x_reg <= rx;
            prev_y_reg <= ry;
            if (!have_prev_reg)
            begin
                first_x_reg <= rx;
                first_y_reg <= ry;
            end
        end
        ax_reg <= ein_ax;
        ay_reg <= ein_ay;
        bx_reg <= ein_bx;
        by_reg <= ein_by;
        m1_reg <= PW'(ax_reg) * PW'(by_reg);
        m2_reg <= PW'(bx_reg) * PW'(ay_reg);
        ex_reg <= (C+1)'(ax_reg) + (C+1)'(bx_reg);
        ey_reg <= (C+1)'(ay_reg) + (C+1)'(by_reg);
        cr_reg <= m1_reg - m2_reg;
        fx_reg <= ex_reg;
        fy_reg <= ey_reg;
        if (state_reg == S_IDLE)
        begin
            area_reg <= '0;
            sumx_reg <= '0;
            sumy_reg <= '0;
        end
        else if (c_v_reg)
        begin
            area_reg <= area_reg + SW'(cr_reg);
            sumx_reg <= sumx_reg + SW'(tx);
            sumy_reg <= sumy_reg + SW'(ty);
        end
        if (state_reg == S_DRAIN)
        begin
            den_reg <= DW'(area_reg) * DW'(3);
        end
        qx_reg  <= qx_next;
        kind_reg <= kind_next;
        rx_reg  <= rx_next;
        ry_reg  <= ry_next;
        idx_reg <= idx_next;
        st_reg  <= st_next;
    end

    assign busy         = state_reg != S_IDLE;
    assign valid        = valid_reg;
    assign kind         = kind_reg;
    assign res_x        = rx_reg;
    assign res_y        = ry_reg;
    assign vertex_index = idx_reg;
    assign status       = st_reg;
endmodule

[hdl/pcs_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module pcs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[hdl/pcs_divider.sv]
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
module pcs_divider #(
    parameter int W = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                go,
    input  logic signed [W-1:0] num,
    input  logic signed [W-1:0] den,
    output logic                done,
    output logic signed [W-1:0] quo
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  q_reg, q_next;
    logic [W:0]    r_reg, r_next;
    logic [W-1:0]  d_reg, d_next;
    logic          neg_reg, neg_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          run_reg, run_next;
    logic          done_reg, done_next;
    logic [W:0]    trial;
    logic [W:0]    shifted;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        shifted   = {r_reg[W-1:0], q_reg[W-1]};
        trial     = shifted - {1'b0, d_reg};
        if (go)
        begin
            q_next   = num[W-1] ? -num : num;
            d_next   = den[W-1] ? -den : den;
            neg_next = num[W-1] ^ den[W-1];
            r_next   = '0;
            cnt_next = CW'(W);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (!trial[W])
            begin
                r_next = trial;
                q_next = {q_reg[W-2:0], 1'b1};
            end
            else
            begin
                r_next = shifted;
                q_next = {q_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    assign done = done_reg;
    assign quo  = neg_reg ? -q_reg : q_reg;
endmodule
